// ===== hdl/csd_pkg.sv =====
// Shared types and constants for the COBS stream deframer.
// Used by every module of the block; depends on nothing else.
package csd_pkg;

  localparam int MAX_DECODED = 8192;
  localparam int INDEX_BITS  = 16;
  localparam int LEN_BITS    = $clog2(MAX_DECODED + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CODE_FULL  = 8'hFF;
  localparam logic [7:0] BYTE_DELIM = 8'h00;

  localparam logic       KIND_DATA = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  decoded_byte;
    logic [15:0] frame_number;
    logic [13:0] decoded_length;
    logic [1:0]  frame_status;
  } result_t;

  typedef enum logic {
    OP_BYTE,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       truncated;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/csd_front.sv =====
// Front end: accepts raw bytes, tracks COBS group state and issues decode operations.
// Depends on csd_pkg.
module csd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  csd_pkg::item_t        item,
  output csd_pkg::push_t        push
);
  import csd_pkg::*;

  logic [7:0] group_left, group_left_next;
  logic       group_full, group_full_next;
  logic       zero_pending, zero_pending_next;
  logic       frame_open, frame_open_next;
  logic       delim;

  assign delim = item.end_of_stream || (item.raw_byte == BYTE_DELIM);

  always_comb begin
    group_left_next   = group_left;
    group_full_next   = group_full;
    zero_pending_next = zero_pending;
    frame_open_next   = frame_open;
    push.valid        = 1'b0;
    push.op.kind      = OP_BYTE;
    push.op.data      = item.raw_byte;
    push.op.truncated = (group_left != 8'd0);
    if (accept) begin
      if (delim) begin
        push.valid        = frame_open;
        push.op.kind      = OP_END;
        group_left_next   = 8'd0;
        group_full_next   = 1'b0;
        zero_pending_next = 1'b0;
        frame_open_next   = 1'b0;
      end else if (group_left == 8'd0) begin
        frame_open_next   = 1'b1;
        push.valid        = zero_pending;
        push.op.data      = BYTE_DELIM;
        group_full_next   = (item.raw_byte == CODE_FULL);
        group_left_next   = item.raw_byte - 8'd1;
        zero_pending_next = (item.raw_byte == 8'd1);
      end else begin
        frame_open_next = 1'b1;
        push.valid      = 1'b1;
        group_left_next = group_left - 8'd1;
        if (group_left == 8'd1 && !group_full) begin
          zero_pending_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_left   <= 8'd0;
      group_full   <= 1'b0;
      zero_pending <= 1'b0;
      frame_open   <= 1'b0;
    end else begin
      group_left   <= group_left_next;
      group_full   <= group_full_next;
      zero_pending <= zero_pending_next;
      frame_open   <= frame_open_next;
    end
  end

endmodule

// ===== hdl/csd_queue.sv =====
// Short register queue of decode operations between the front and back ends.
// Depends on csd_pkg.
module csd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  csd_pkg::push_t         push,
  input  logic                   pop,
  output csd_pkg::op_t           head,
  output csd_pkg::queue_status_t status
);
  import csd_pkg::*;

  op_t                  entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_pop;

  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && status.full))
    else $error("Request written into a full queue.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("Queue count did not follow a lone write.");

endmodule

// ===== hdl/csd_back.sv =====
// Back end: counts decoded bytes, forms data and frame status results in the output register.
// Depends on csd_pkg.
module csd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  csd_pkg::op_t           head,
  input  csd_pkg::queue_status_t qstat,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output csd_pkg::result_t       result
);
  import csd_pkg::*;

  logic [LEN_BITS-1:0]   length_count, length_count_next;
  logic                  overflowed, overflowed_next;
  logic [INDEX_BITS-1:0] frame_counter, frame_counter_next;
  logic [31:0]           frame_wide;
  logic [31:0]           length_wide;
  logic                  at_max;
  result_t               result_next;

  assign pop         = !qstat.empty && (!result_valid || !result_stall);
  assign frame_wide  = 32'(frame_counter);
  assign length_wide = 32'(length_count);
  assign at_max      = (length_count >= LEN_BITS'(MAX_DECODED));

  always_comb begin
    length_count_next          = length_count;
    overflowed_next            = overflowed;
    frame_counter_next         = frame_counter;
    result_next.result_kind    = KIND_DATA;
    result_next.decoded_byte   = head.data;
    result_next.frame_number   = frame_wide[15:0];
    result_next.decoded_length = 14'd0;
    result_next.frame_status   = STATUS_OK;
    unique case (head.kind)
      OP_BYTE: begin
        if (at_max) begin
          overflowed_next = 1'b1;
        end else begin
          length_count_next = length_count + 1'b1;
        end
      end
      OP_END: begin
        result_next.result_kind    = KIND_END;
        result_next.decoded_byte   = 8'd0;
        result_next.decoded_length = length_wide[13:0];
        if (head.truncated) begin
          result_next.frame_status = STATUS_TRUNCATED;
        end else if (overflowed) begin
          result_next.frame_status = STATUS_OVERFLOW;
        end
        frame_counter_next = frame_counter + 1'b1;
        length_count_next  = '0;
        overflowed_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count  <= '0;
      overflowed    <= 1'b0;
      frame_counter <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (pop) begin
        length_count  <= length_count_next;
        overflowed    <= overflowed_next;
        frame_counter <= frame_counter_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length_count <= LEN_BITS'(MAX_DECODED))
    else $error("Decoded length count passed its maximum.");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == OP_END) |=> (length_count == '0 && !overflowed))
    else $error("Frame state not cleared after a frame end.");

  a_ovf_at_max: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> at_max)
    else $error("Overflow flagged below the maximum length.");

endmodule

// ===== hdl/cobs_stream_deframer_unit.sv =====
// COBS stream deframer: one raw byte per cycle in, decoded bytes and frame status out.
// Path from an accepted byte to its result: queue write, then output register.
// Throughput: one byte per cycle while the queue is not full, set by the combinational group update in the front end.
// Reset (synchronous, active high) clears group, frame and counter state and empties the queue.
// Input stalls only while the four-entry operation queue is full.
module cobs_stream_deframer_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  csd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output csd_pkg::result_t result
);
  import csd_pkg::*;

  push_t         push;
  op_t           head;
  queue_status_t qstat;
  logic          pop;
  logic          accept;

  assign item_stall = qstat.full;
  assign accept     = item_valid && !item_stall;

  csd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .push   (push)
  );

  csd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (qstat)
  );

  csd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
